// ===== sv/swag_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swag_pkg
// Shared constants, codes and types of the strided wrap address generator.
// ----------------------------------------------------------------------------
package swag_pkg;

  localparam int ADDR_BITS = 32;
  localparam int OFF_W     = ADDR_BITS + 1;      // offsets and touch limit
  localparam int DIV_W     = ADDR_BITS + 2;      // divider operand width
  localparam int CNT_W     = $clog2(DIV_W + 1);

  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  // power-of-two word sizes, accepted whether or not they are a multiple of four
  localparam logic [8:0] WS_16 = 9'd16;
  localparam logic [8:0] WS_8  = 9'd8;
  localparam logic [8:0] WS_4  = 9'd4;
  localparam logic [8:0] WS_2  = 9'd2;
  localparam logic [8:0] WS_1  = 9'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_WORD  = 3'd1;
  localparam logic [2:0] ST_WORD_OVER = 3'd2;
  localparam logic [2:0] ST_FIRST_OOB = 3'd3;
  localparam logic [2:0] ST_STRADDLE  = 3'd4;
  localparam logic [2:0] ST_IDLE      = 3'd5;

  localparam logic [1:0] MODE_ZERO      = 2'd0;
  localparam logic [1:0] MODE_NOWRAP    = 2'd1;
  localparam logic [1:0] MODE_WRAP_ZERO = 2'd2;
  localparam logic [1:0] MODE_WRAP_GEN  = 2'd3;

  localparam logic [1:0] K_NEXT   = 2'd0;
  localparam logic [1:0] K_START  = 2'd1;
  localparam logic [1:0] K_REJECT = 2'd2;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] first_offset;
    logic [31:0] access_count;
    logic [31:0] stride;
    logic [8:0]  word_size;
  } cmd_t;

  typedef struct packed {
    logic [32:0] address;
    logic        access_valid;
    logic        last;
    logic [2:0]  status;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/strided_wrap_address_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// strided_wrap_address_generator
// Word addresses of a strided walk over a buffer, with wrap handling.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: first_offset, access_count, stride,
//                                   word_size; tuser: func
// m_*       out  m_tvalid/m_tready  tdata: address; tuser: access_valid,
//                                   status; tlast: last
// cfg_*     in   cfg_we             cfg_index 0 base, 1 size; cfg_data
//
// A next request's result is registered: the request waits in the queue until the
// engine pops it, and its result is then written to the result register. The engine
// takes one next request per cycle while it is idle and the result register is free;
// a general-wrap step adds a division on the shared divider. A start takes up to five
// divisions. A two-entry request queue lets the input keep flowing while the engine
// or the result register stalls. Reset is synchronous and empties both.
// ----------------------------------------------------------------------------
module strided_wrap_address_generator
  import swag_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,   // first_offset, access_count, stride, word_size
  input  wire logic [0:0]   s_tuser,   // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,   // address
  output logic [3:0]        m_tuser,   // access_valid, status
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [31:0] buffer_base;
  logic [31:0] buffer_size;
  cmd_t        head;
  logic        head_valid;
  logic        pop;
  res_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= '0;
      buffer_size <= 32'd4096;
    end else if (cfg_we) begin
      case (cfg_index[0])
        REG_BASE: buffer_base <= cfg_data & ADDR_MASK;
        REG_SIZE: buffer_size <= cfg_data & ADDR_MASK;
        default: begin
        end
      endcase
    end
  end

  swag_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .size       (buffer_size),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  swag_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .base       (buffer_base),
    .size       (buffer_size),
    .o_valid    (m_tvalid),
    .o_ready    (m_tready),
    .o_res      (res)
  );

  assign m_tdata = {7'b0, res.address};
  assign m_tuser = {res.status, res.access_valid};
  assign m_tlast = res.last;

endmodule
`default_nettype wire

// ===== sv/swag_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swag_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module swag_div
  import swag_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient,
  output logic      [DIV_W-1:0] remainder
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             neg;

  assign shifted = {remainder, quotient[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign neg     = diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], ~neg};
      if (!neg) begin
        remainder <= diff[DIV_W-1:0];
      end else begin
        remainder <= shifted[DIV_W-1:0];
      end
    end
  end

  a_no_relaunch: assert property (@(posedge clk) disable iff (rst) go |-> !busy)
    else $error("divider launched while busy");

endmodule
`default_nettype wire

// ===== sv/swag_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swag_front
// Takes requests, runs the start checks and queues classified commands.
// ----------------------------------------------------------------------------
module swag_front
  import swag_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic [0:0]   s_tuser,
  input  wire logic [31:0]  size,
  output cmd_t              head,
  output logic              head_valid,
  input  wire logic         pop
);

  cmd_t        q [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push;
  cmd_t        cmd;
  logic [31:0] first;
  logic [8:0]  w;
  logic        pow_ok;

  assign first  = s_tdata[31:0] & ADDR_MASK;
  assign w      = s_tdata[104:96];
  assign pow_ok = (w == WS_1) || (w == WS_2) || (w == WS_4) || (w == WS_8) || (w == WS_16);

  always_comb begin
    cmd.first_offset = first;
    cmd.access_count = s_tdata[63:32];
    cmd.stride       = s_tdata[95:64];
    cmd.word_size    = w;
    if (w == '0) begin
      cmd.status = ST_BAD_WORD;
    end else if (32'(w) > size) begin
      cmd.status = ST_WORD_OVER;
    end else if (({1'b0, first} + 33'(w)) > {1'b0, size}) begin
      cmd.status = ST_FIRST_OOB;
    end else if (!pow_ok && (w[1:0] != 2'b00)) begin
      cmd.status = ST_BAD_WORD;
    end else begin
      cmd.status = ST_OK;
    end
    if (s_tuser[0]) begin
      cmd.kind = K_NEXT;
    end else if (cmd.status != ST_OK) begin
      cmd.kind = K_REJECT;
    end else begin
      cmd.kind = K_START;
    end
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign head       = q[rd_ptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/swag_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swag_back
// Walk engine: sets up walks with the shared divider and issues addresses.
// ----------------------------------------------------------------------------
module swag_back
  import swag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        head,
  input  wire logic        head_valid,
  output logic             pop,
  input  wire logic [31:0] base,
  input  wire logic [31:0] size,
  output logic             o_valid,
  input  wire logic        o_ready,
  output res_t             o_res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STRIDE = 3'd1;
  localparam logic [2:0] S_FIT    = 3'd2;
  localparam logic [2:0] S_SPAN   = 3'd3;
  localparam logic [2:0] S_WORD   = 3'd4;
  localparam logic [2:0] S_FIRST  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;
  localparam logic [2:0] S_WRAP   = 3'd7;

  logic [2:0]       state;
  logic [OFF_W-1:0] cur_off;
  logic [31:0]      remaining;
  logic [31:0]      reduced_stride;
  logic [OFF_W-1:0] touch_limit;
  logic [1:0]       walk_mode;
  logic             walking;

  logic [31:0]      l_first, l_count, l_s;
  logic             l_neg;
  logic [8:0]       l_w;
  logic [2:0]       l_status;
  logic [1:0]       l_mode;

  logic             div_go, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_r;

  logic             out_free;
  logic [DIV_W-1:0] size_w, first_w, w_w, nxt, addr_sum;
  logic [31:0]      s_calc;
  logic [OFF_W-1:0] modulus;

  swag_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign out_free = !o_valid || o_ready;
  assign pop      = (state == S_IDLE) && head_valid && (out_free || head.kind == K_START);
  assign size_w   = DIV_W'(size);
  assign first_w  = DIV_W'(l_first);
  assign w_w      = DIV_W'(l_w);
  assign nxt      = DIV_W'(cur_off) + DIV_W'(reduced_stride);
  assign addr_sum = DIV_W'(base) + DIV_W'(cur_off);
  assign modulus  = touch_limit - 1'b1;
  assign s_calc   = l_neg ? ((div_r != '0) ? 32'(size_w - div_r) : 32'd0) : 32'(div_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cur_off        <= '0;
      remaining      <= '0;
      reduced_stride <= '0;
      touch_limit    <= '0;
      walk_mode      <= MODE_ZERO;
      walking        <= 1'b0;
      o_valid        <= 1'b0;
      div_go         <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (o_ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.kind)
              K_NEXT: begin
                o_valid <= 1'b1;
                if (!walking || remaining == '0) begin
                  walking <= 1'b0;
                  o_res   <= '{address: '0, access_valid: 1'b0, last: 1'b0, status: ST_IDLE};
                end else begin
                  o_res <= '{address: 33'(addr_sum[OFF_W-1:0]), access_valid: 1'b1,
                             last: (remaining == 32'd1), status: ST_OK};
                  remaining <= remaining - 1'b1;
                  if (remaining == 32'd1) begin
                    walking <= 1'b0;
                  end else begin
                    case (walk_mode)
                      MODE_ZERO: begin
                      end
                      MODE_NOWRAP: begin
                        cur_off <= OFF_W'(nxt);
                      end
                      MODE_WRAP_ZERO: begin
                        cur_off <= (nxt >= DIV_W'(touch_limit)) ? '0 : OFF_W'(nxt);
                      end
                      default: begin
                        if (nxt >= DIV_W'(touch_limit)) begin
                          if (modulus == '0) begin
                            cur_off <= '0;
                          end else begin
                            div_go <= 1'b1;
                            div_a  <= nxt;
                            div_b  <= DIV_W'(modulus);
                            state  <= S_WRAP;
                          end
                        end else begin
                          cur_off <= OFF_W'(nxt);
                        end
                      end
                    endcase
                  end
                end
              end
              K_START: begin
                l_first  <= head.first_offset;
                l_count  <= head.access_count;
                l_neg    <= head.stride[31];
                l_w      <= head.word_size;
                l_status <= ST_OK;
                div_go   <= 1'b1;
                div_a    <= head.stride[31] ? (DIV_W'(33'h1_0000_0000) - DIV_W'(head.stride))
                                            : DIV_W'(head.stride);
                div_b    <= size_w;
                state    <= S_STRIDE;
              end
              default: begin
                o_valid   <= 1'b1;
                o_res     <= '{address: '0, access_valid: 1'b0, last: 1'b0,
                               status: head.status};
                walking   <= 1'b0;
                remaining <= '0;
              end
            endcase
          end
        end
        S_STRIDE: begin
          if (div_done) begin
            l_s <= s_calc;
            if (s_calc == '0) begin
              l_mode <= MODE_ZERO;
              state  <= S_FINISH;
            end else begin
              div_go <= 1'b1;
              div_a  <= size_w - first_w - w_w + 1'b1;
              div_b  <= DIV_W'(s_calc);
              state  <= S_FIT;
            end
          end
        end
        S_FIT: begin
          if (div_done) begin
            if (DIV_W'(l_count) <= div_q) begin
              l_mode <= MODE_NOWRAP;
              state  <= S_FINISH;
            end else begin
              div_go <= 1'b1;
              div_b  <= DIV_W'(l_s);
              if (l_w > WS_1) begin
                div_a <= size_w - first_w;
                state <= S_SPAN;
              end else begin
                div_a <= first_w;
                state <= S_FIRST;
              end
            end
          end
        end
        S_SPAN: begin
          if (div_done) begin
            div_go <= 1'b1;
            div_a  <= div_r;
            div_b  <= w_w;
            state  <= S_WORD;
          end
        end
        S_WORD: begin
          if (div_done) begin
            if (div_r != '0) begin
              l_status <= ST_STRADDLE;
              state    <= S_FINISH;
            end else begin
              div_go <= 1'b1;
              div_a  <= first_w;
              div_b  <= DIV_W'(l_s);
              state  <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (div_done) begin
            l_mode <= (div_r == '0) ? MODE_WRAP_ZERO : MODE_WRAP_GEN;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_res   <= '{address: '0, access_valid: 1'b0,
                         last: (l_status == ST_OK) && (l_count == '0), status: l_status};
            if (l_status == ST_OK) begin
              cur_off        <= OFF_W'(l_first);
              remaining      <= l_count;
              reduced_stride <= l_s;
              touch_limit    <= OFF_W'(size_w - w_w + 1'b1);
              walk_mode      <= l_mode;
              walking        <= (l_count != '0);
            end else begin
              walking   <= 1'b0;
              remaining <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_WRAP: begin
          if (div_done) begin
            cur_off <= OFF_W'(div_r);
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    walking == (remaining != '0))
    else $error("walking flag out of step with access count");

  a_in_bounds: assert property (@(posedge clk) disable iff (rst)
    walking && state != S_WRAP |-> cur_off < touch_limit)
    else $error("offset beyond touch limit during walk");

  a_wrap_mode: assert property (@(posedge clk) disable iff (rst)
    state == S_WRAP |-> walk_mode == MODE_WRAP_GEN && walking)
    else $error("wrap division outside general wrap walk");

  a_access_ok: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_res.access_valid |-> o_res.status == ST_OK && (!o_res.last || !walking))
    else $error("access result with bad status or walk left open");

endmodule
`default_nettype wire
